>>> src/cfp_pkg.sv
// cfp_pkg: shared types, codes and the CRC-32C byte step for the frame parser.
// No dependencies; used by the interfaces, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 5;
  localparam logic [31:0] CRC32C_POLY      = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;

  // parse phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ULEN    = 3'd1;
  localparam logic [2:0] PH_CLEN    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CODEC  = 3'd1;
  localparam logic [2:0] ST_LEN_OVER   = 3'd2;
  localparam logic [2:0] ST_BAD_VARINT = 3'd3;
  localparam logic [2:0] ST_CRC_ERR    = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;

  // codec indexes
  localparam logic [1:0] CODEC_RAW        = 2'd0;
  localparam logic [1:0] CODEC_COMPRESSED = 2'd1;
  localparam logic [1:0] CODEC_PACKED     = 2'd2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_CODEC_RAW        = 2'd0;
  localparam logic [1:0] CFG_CODEC_COMPRESSED = 2'd1;
  localparam logic [1:0] CFG_CODEC_PACKED     = 2'd2;
  localparam logic [1:0] CFG_MAX_ULEN         = 2'd3;

  typedef logic [1:0]  cfg_index_t;
  typedef logic [31:0] cfg_data_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [1:0]  codec_index;
    logic [31:0] decoded_len;
    logic [31:0] carried_len;
    logic        last_result;
  } result_t;

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC32C_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> src/cfp_if.sv
// Valid/ready channel interfaces for the frame parser: input bytes, results, config writes.
// Depends on cfp_pkg.
`timescale 1ns / 1ps

interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       source_end;

  modport source (output valid, output data_byte, output source_end, input ready);
  modport sink (input valid, input data_byte, input source_end, output ready);
endinterface

interface cfp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic [1:0]  codec_index;
  logic [31:0] decoded_len;
  logic [31:0] carried_len;
  logic        last_result;

  modport source (output valid, output item_kind, output payload_byte, output frame_status,
                  output codec_index, output decoded_len, output carried_len,
                  output last_result, input ready);
  modport sink (input valid, input item_kind, input payload_byte, input frame_status,
                input codec_index, input decoded_len, input carried_len,
                input last_result, output ready);
endinterface

interface cfp_cfg_if;
  logic                valid;
  logic                ready;
  cfp_pkg::cfg_index_t index;
  cfp_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/crc32c_checked_frame_parser.sv
// crc32c_checked_frame_parser: byte-serial parser for varint-prefixed frames with CRC-32C.
// Depends on cfp_pkg and the channel interfaces in cfp_if.sv.
//
//   channel  | dir | payload                                              | transfer
//   in_ch    | in  | data_byte, source_end                                | valid & ready
//   out_ch   | out | item_kind, payload_byte, frame_status, codec_index,  | valid & ready
//            |     | decoded_len, carried_len, last_result                |
//   cfg_ch   | in  | index (2b), data (32b)                               | valid & ready
//
// One input byte per cycle while in_ch.ready is high; parse, CRC step and result build
// happen in the transfer cycle. Results go into a 4-entry output queue; a byte yields
// zero, one or two results. in_ch.ready drops while the queue holds more than two results;
// a byte with two results needs two out_ch transfers. cfg_ch is always ready.
// rst_n is synchronous; it restores register defaults and empties the queue.
`timescale 1ns / 1ps

module crc32c_checked_frame_parser (
  input  logic      clk,
  input  logic      rst_n,
  cfp_in_if.sink    in_ch,
  cfp_out_if.source out_ch,
  cfp_cfg_if.sink   cfg_ch
);
  import cfp_pkg::*;

  localparam int QDEPTH = 4;

  logic [7:0]  codec_raw_r, codec_comp_r, codec_packed_r;
  logic [31:0] max_ulen_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  vcnt_r, vcnt_nxt;
  logic [1:0]  codec_r, codec_nxt;
  logic [31:0] ulen_r, ulen_nxt;
  logic [31:0] ptotal_r, ptotal_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] cshift_r, cshift_nxt;
  logic [1:0]  ccnt_r, ccnt_nxt;

  result_t     q_mem_r [QDEPTH];
  logic [1:0]  wr_ptr_r, rd_ptr_r;
  logic [2:0]  count_r;

  logic        in_xfer, out_xfer;
  logic [7:0]  b;
  logic [2:0]  err;
  logic        done, pay_en, rep_en;
  logic [31:0] acc_val, shifted, cshift_val;
  logic [2:0]  vcnt_inc;
  result_t     pay_res, rep_res, res_a;
  logic [1:0]  n_push;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (count_r <= 3'd2);
  assign cfg_ch.ready = 1'b1;
  assign b            = in_ch.data_byte;

  always_comb begin
    case (vcnt_r)
      3'd0:    shifted = {25'd0, b[6:0]};
      3'd1:    shifted = {18'd0, b[6:0], 7'd0};
      3'd2:    shifted = {11'd0, b[6:0], 14'd0};
      3'd3:    shifted = {4'd0, b[6:0], 21'd0};
      3'd4:    shifted = {b[3:0], 28'd0};
      default: shifted = 32'd0;
    endcase
  end

  assign acc_val    = acc_r | shifted;
  assign vcnt_inc   = vcnt_r + 3'd1;
  assign cshift_val = cshift_r | ({24'd0, b} << {ccnt_r, 3'b000});

  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    vcnt_nxt   = vcnt_r;
    codec_nxt  = codec_r;
    ulen_nxt   = ulen_r;
    ptotal_nxt = ptotal_r;
    rem_nxt    = rem_r;
    crc_nxt    = crc_r;
    cshift_nxt = cshift_r;
    ccnt_nxt   = ccnt_r;
    err        = ST_OK;
    done       = 1'b0;
    pay_en     = 1'b0;
    case (phase_r)
      PH_ULEN, PH_CLEN: begin
        crc_nxt = crc32c_byte(crc_r, b);
        if (b[7]) begin
          acc_nxt  = acc_val;
          vcnt_nxt = vcnt_inc;
          if (vcnt_inc >= 3'(MAX_VARINT_BYTES)) begin
            err = ST_BAD_VARINT;
          end
        end else begin
          acc_nxt  = 32'd0;
          vcnt_nxt = 3'd0;
          if (phase_r == PH_ULEN && acc_val > max_ulen_r) begin
            ulen_nxt = acc_val;
            err      = ST_LEN_OVER;
          end else if (phase_r == PH_ULEN && codec_r == CODEC_COMPRESSED) begin
            ulen_nxt  = acc_val;
            phase_nxt = PH_CLEN;
          end else begin
            if (phase_r == PH_ULEN) begin
              ulen_nxt = acc_val;
            end
            ptotal_nxt = acc_val;
            rem_nxt    = acc_val;
            phase_nxt  = (acc_val != 32'd0) ? PH_PAYLOAD : PH_CRC;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_nxt = crc32c_byte(crc_r, b);
        pay_en  = 1'b1;
        rem_nxt = rem_r - 32'd1;
        if (rem_r == 32'd1) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        if (ccnt_r == 2'd3) begin
          err  = (cshift_val != ~crc_r) ? ST_CRC_ERR : ST_OK;
          done = 1'b1;
        end else begin
          cshift_nxt = cshift_val;
          ccnt_nxt   = ccnt_r + 2'd1;
        end
      end
      default: begin
        acc_nxt    = 32'd0;
        vcnt_nxt   = 3'd0;
        ulen_nxt   = 32'd0;
        ptotal_nxt = 32'd0;
        rem_nxt    = 32'd0;
        cshift_nxt = 32'd0;
        ccnt_nxt   = 2'd0;
        crc_nxt    = crc32c_byte(CRC_INIT, b);
        phase_nxt  = PH_ULEN;
        codec_nxt  = CODEC_RAW;
        if (b == codec_raw_r) begin
          codec_nxt = CODEC_RAW;
        end else if (b == codec_comp_r) begin
          codec_nxt = CODEC_COMPRESSED;
        end else if (b == codec_packed_r) begin
          codec_nxt = CODEC_PACKED;
        end else begin
          err = ST_BAD_CODEC;
        end
      end
    endcase

    rep_en = (err != ST_OK) || done || (in_ch.source_end && phase_nxt != PH_IDLE);

    pay_res                     = '0;
    pay_res.item_kind           = KIND_PAYLOAD;
    pay_res.payload_byte        = b;
    pay_res.last_result         = !rep_en;

    rep_res                     = '0;
    rep_res.item_kind           = KIND_REPORT;
    rep_res.frame_status        = ((err != ST_OK) || done) ? err : ST_TRUNCATED;
    rep_res.codec_index         = codec_nxt;
    rep_res.decoded_len         = ulen_nxt;
    rep_res.carried_len         = ptotal_nxt - rem_nxt;
    rep_res.last_result         = 1'b1;

    if (rep_en) begin
      phase_nxt  = PH_IDLE;
      acc_nxt    = 32'd0;
      vcnt_nxt   = 3'd0;
      codec_nxt  = CODEC_RAW;
      ulen_nxt   = 32'd0;
      ptotal_nxt = 32'd0;
      rem_nxt    = 32'd0;
      crc_nxt    = CRC_INIT;
      cshift_nxt = 32'd0;
      ccnt_nxt   = 2'd0;
    end
  end

  assign res_a  = pay_en ? pay_res : rep_res;
  assign n_push = in_xfer ? ({1'b0, pay_en} + {1'b0, rep_en}) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_raw_r    <= 8'd0;
      codec_comp_r   <= 8'd1;
      codec_packed_r <= 8'd2;
      max_ulen_r     <= 32'd1048576;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_CODEC_RAW:        codec_raw_r    <= cfg_ch.data[7:0];
        CFG_CODEC_COMPRESSED: codec_comp_r   <= cfg_ch.data[7:0];
        CFG_CODEC_PACKED:     codec_packed_r <= cfg_ch.data[7:0];
        CFG_MAX_ULEN:         max_ulen_r     <= cfg_ch.data;
        default:              max_ulen_r     <= max_ulen_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      acc_r    <= 32'd0;
      vcnt_r   <= 3'd0;
      codec_r  <= CODEC_RAW;
      ulen_r   <= 32'd0;
      ptotal_r <= 32'd0;
      rem_r    <= 32'd0;
      crc_r    <= CRC_INIT;
      cshift_r <= 32'd0;
      ccnt_r   <= 2'd0;
    end else if (in_xfer) begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      vcnt_r   <= vcnt_nxt;
      codec_r  <= codec_nxt;
      ulen_r   <= ulen_nxt;
      ptotal_r <= ptotal_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      cshift_r <= cshift_nxt;
      ccnt_r   <= ccnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + {1'b0, out_xfer};
      count_r  <= count_r + {1'b0, n_push} - {2'b00, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[wr_ptr_r] <= res_a;
    end
    if (n_push == 2'd2) begin
      q_mem_r[wr_ptr_r + 2'd1] <= rep_res;
    end
  end

  assign out_ch.valid               = (count_r != 3'd0);
  assign out_ch.item_kind           = q_mem_r[rd_ptr_r].item_kind;
  assign out_ch.payload_byte        = q_mem_r[rd_ptr_r].payload_byte;
  assign out_ch.frame_status        = q_mem_r[rd_ptr_r].frame_status;
  assign out_ch.codec_index         = q_mem_r[rd_ptr_r].codec_index;
  assign out_ch.decoded_len         = q_mem_r[rd_ptr_r].decoded_len;
  assign out_ch.carried_len         = q_mem_r[rd_ptr_r].carried_len;
  assign out_ch.last_result         = q_mem_r[rd_ptr_r].last_result;

endmodule

>>> src/cfp_checker.sv
// cfp_checker: port-level assertions for the frame parser, bound to the top level.
// Depends on cfp_pkg and crc32c_checked_frame_parser.
`timescale 1ns / 1ps

module cfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        item_kind,
  input logic [7:0]  payload_byte,
  input logic [2:0]  frame_status,
  input logic [1:0]  codec_index,
  input logic [31:0] decoded_len,
  input logic [31:0] carried_len,
  input logic        last_result
);
  import cfp_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(item_kind) && $stable(payload_byte)
      && $stable(frame_status) && $stable(last_result))
    else $error("stalled result changed");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_PAYLOAD |-> frame_status == ST_OK
      && codec_index == CODEC_RAW && decoded_len == 32'd0 && carried_len == 32'd0)
    else $error("payload transfer carries report fields");

  a_report_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && item_kind == KIND_REPORT |-> last_result && payload_byte == 8'd0
      && frame_status <= ST_TRUNCATED && codec_index <= CODEC_PACKED)
    else $error("malformed frame report");

endmodule

bind crc32c_checked_frame_parser cfp_checker u_cfp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .item_kind           (out_ch.item_kind),
  .payload_byte        (out_ch.payload_byte),
  .frame_status        (out_ch.frame_status),
  .codec_index         (out_ch.codec_index),
  .decoded_len         (out_ch.decoded_len),
  .carried_len         (out_ch.carried_len),
  .last_result         (out_ch.last_result)
);

>>> tb/crc32c_checked_frame_parser_tb.sv
// Testbench for crc32c_checked_frame_parser: random framed byte streams with CRC-32C,
// checked result by result against an in-bench parser model. Depends on cfp_pkg,
// the channel interfaces in cfp_if.sv and the RTL top level.
`timescale 1ns / 1ps

module crc32c_checked_frame_parser_tb;
  import cfp_pkg::*;

  localparam int SHOW_LIMIT   = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES  = 112;

  typedef struct packed {
    logic [7:0]  raw_code;
    logic [7:0]  comp_code;
    logic [7:0]  packed_code;
    logic [31:0] ulen_cap;
  } parser_cfg_t;

  typedef enum int {
    FRM_CLEAN,
    FRM_BAD_CRC,
    FRM_TRUNCATED,
    FRM_CORRUPT,
    FRM_LONG_VARINT,
    FRM_OVER_CAP
  } frame_defect_t;

  class frame_tracker_t;
    logic [7:0]  raw_code;
    logic [7:0]  comp_code;
    logic [7:0]  packed_code;
    logic [31:0] ulen_cap;

    logic [2:0]  phase;
    logic [31:0] acc;
    logic [2:0]  vcount;
    logic [1:0]  codec;
    logic [31:0] ulen;
    logic [31:0] plen;
    logic [31:0] remaining;
    logic [31:0] crc;
    logic [31:0] stored;
    logic [1:0]  crc_count;

    result_t awaited_results[$];
    int      errors;

    function new();
      raw_code    = 8'd0;
      comp_code   = 8'd1;
      packed_code = 8'd2;
      ulen_cap    = 32'd1048576;
      errors      = 0;
      clear_frame();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r = r >> 1;
        if (fb) r = r ^ CRC32C_POLY;
      end
      return r;
    endfunction

    function void clear_frame();
      phase     = PH_IDLE;
      acc       = '0;
      vcount    = '0;
      codec     = CODEC_RAW;
      ulen      = '0;
      plen      = '0;
      remaining = '0;
      crc       = CRC_INIT;
      stored    = '0;
      crc_count = '0;
    endfunction

    function void start_payload(logic [31:0] len);
      plen      = len;
      remaining = len;
      phase     = (len != 0) ? PH_PAYLOAD : PH_CRC;
    endfunction

    function void set_register(cfg_index_t idx, cfg_data_t val);
      case (idx)
        CFG_CODEC_RAW:        raw_code    = val[7:0];
        CFG_CODEC_COMPRESSED: comp_code   = val[7:0];
        CFG_CODEC_PACKED:     packed_code = val[7:0];
        CFG_MAX_ULEN:         ulen_cap    = val;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic last_avail);
      result_t     step_q[$];
      result_t     r;
      logic [2:0]  err;
      bit          done;
      logic [3:0]  cnt;
      logic [31:0] chunk;
      logic [31:0] v;
      logic [1:0]  k;
      err  = ST_OK;
      done = 0;
      if (phase > PH_CRC) phase = PH_IDLE;
      case (phase)
        PH_IDLE: begin
          clear_frame();
          crc = crc_step(crc, b);
          if (b == raw_code) codec = CODEC_RAW;
          else if (b == comp_code) codec = CODEC_COMPRESSED;
          else if (b == packed_code) codec = CODEC_PACKED;
          else err = ST_BAD_CODEC;
          phase = PH_ULEN;
        end
        PH_ULEN, PH_CLEN: begin
          crc = crc_step(crc, b);
          cnt = {1'b0, vcount};
          if (cnt < MAX_VARINT_BYTES) begin
            chunk = {25'd0, b[6:0]};
            acc = acc | (chunk << (7 * cnt));
          end
          cnt = cnt + 4'd1;
          vcount = cnt[2:0];
          if (b[7]) begin
            if (cnt >= MAX_VARINT_BYTES) err = ST_BAD_VARINT;
          end else begin
            v = acc;
            acc = '0;
            vcount = '0;
            if (phase == PH_ULEN) begin
              ulen = v;
              if (v > ulen_cap) err = ST_LEN_OVER;
              else if (codec == CODEC_COMPRESSED) phase = PH_CLEN;
              else start_payload(v);
            end else begin
              start_payload(v);
            end
          end
        end
        PH_PAYLOAD: begin
          crc = crc_step(crc, b);
          r = '0;
          r.item_kind = KIND_PAYLOAD;
          r.payload_byte = b;
          step_q.push_back(r);
          remaining = remaining - 32'd1;
          if (remaining == 0) phase = PH_CRC;
        end
        default: begin
          k = crc_count;
          stored = stored | ({24'd0, b} << (8 * k));
          if (k == 2'd3) begin
            err  = (stored != ~crc) ? ST_CRC_ERR : ST_OK;
            done = 1;
          end else begin
            crc_count = k + 2'd1;
          end
        end
      endcase

      if (err != ST_OK || done || (last_avail && phase != PH_IDLE)) begin
        r = '0;
        r.item_kind           = KIND_REPORT;
        r.frame_status        = (err != ST_OK || done) ? err : ST_TRUNCATED;
        r.codec_index         = codec;
        r.decoded_len         = ulen;
        r.carried_len         = plen - remaining;
        step_q.push_back(r);
        clear_frame();
      end

      if (step_q.size() > 0) step_q[step_q.size() - 1].last_result = 1'b1;
      foreach (step_q[i]) awaited_results.push_back(step_q[i]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: unexpected result kind=%0d byte=%02h st=%0d codec=%0d ulen=%08h plen=%0d",
                   $realtime, got.item_kind, got.payload_byte, got.frame_status,
                   got.codec_index, got.decoded_len, got.carried_len);
        return;
      end
      want = awaited_results.pop_front();
      if (got.item_kind !== want.item_kind || got.payload_byte !== want.payload_byte ||
          got.frame_status !== want.frame_status || got.codec_index !== want.codec_index ||
          got.decoded_len !== want.decoded_len ||
          got.carried_len !== want.carried_len ||
          got.last_result !== want.last_result) begin
        errors++;
        if (errors <= SHOW_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected kind=%0d byte=%02h st=%0d codec=%0d ulen=%08h plen=%08h last=%0d",
                   want.item_kind, want.payload_byte, want.frame_status, want.codec_index,
                   want.decoded_len, want.carried_len, want.last_result);
          $display("  actual   kind=%0d byte=%02h st=%0d codec=%0d ulen=%08h plen=%08h last=%0d",
                   got.item_kind, got.payload_byte, got.frame_status, got.codec_index,
                   got.decoded_len, got.carried_len, got.last_result);
        end
      end
    endfunction

    function int finish_check();
      if (awaited_results.size() != 0) begin
        if (errors < SHOW_LIMIT)
          $display("%0t: %0d expected results never arrived", $realtime, awaited_results.size());
        errors += awaited_results.size();
      end
      return errors;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic result_ready = 1'b0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   bytes_sent = 0;

  parser_cfg_t cur_cfg = {8'd0, 8'd1, 8'd2, 32'd1048576};
  logic [7:0]  frame_bytes[$];

  parser_cfg_t cfg_plan[8] = '{
    {8'h00, 8'h01, 8'h02, 32'd1048576},
    {8'hFF, 8'h00, 8'h80, 32'hFFFF_FFFF},
    {8'h5A, 8'h5A, 8'hA5, 32'd32},
    {8'h7F, 8'h80, 8'h7F, 32'd0},
    {8'h01, 8'h02, 8'h03, 32'd1000},
    {8'h00, 8'hFF, 8'hFF, 32'd12},
    {8'hC3, 8'h3C, 8'h99, 32'hFFFF_FFFF},
    {8'h10, 8'h20, 8'h30, 32'd7}
  };
  int sender_idle_by_mode[4]    = '{0, 64, 0, 7};
  int receiver_stall_by_mode[4] = '{0, 0, 64, 7};

  frame_tracker_t frame_chk = new();

  cfp_in_if  in_ch();
  cfp_out_if out_ch();
  cfp_cfg_if cfg_ch();

  assign out_ch.ready = result_ready;

  crc32c_checked_frame_parser dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : result_sink
    result_t got;
    if (rst_n && out_ch.valid && result_ready) begin
      got.item_kind           = out_ch.item_kind;
      got.payload_byte        = out_ch.payload_byte;
      got.frame_status        = out_ch.frame_status;
      got.codec_index         = out_ch.codec_index;
      got.decoded_len         = out_ch.decoded_len;
      got.carried_len         = out_ch.carried_len;
      got.last_result         = out_ch.last_result;
      frame_chk.check_result(got);
    end
    result_ready <= rst_n && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last_avail);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.source_end <= last_avail;
    do @(posedge clk); while (!in_ch.ready);
    frame_chk.note_byte(b, last_avail);
    bytes_sent++;
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (frame_chk.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    frame_chk.set_register(idx, val);
  endtask

  task automatic write_config(input parser_cfg_t c);
    write_reg(CFG_CODEC_RAW, {24'd0, c.raw_code});
    write_reg(CFG_CODEC_COMPRESSED, {24'd0, c.comp_code});
    write_reg(CFG_CODEC_PACKED, {24'd0, c.packed_code});
    write_reg(CFG_MAX_ULEN, c.ulen_cap);
    cfg_ch.valid <= 1'b0;
    cur_cfg = c;
  endtask

  // five-byte form now and then: padded encoding with junk in the dropped high bits
  function automatic void push_varint(input logic [31:0] value);
    logic [31:0] v;
    logic [7:0]  b;
    v = value;
    if ($urandom_range(0, 5) == 0) begin
      for (int i = 0; i < 4; i++) frame_bytes.push_back({1'b1, v[7*i +: 7]});
      frame_bytes.push_back({1'b0, 3'($urandom_range(0, 7)), v[31:28]});
    end else begin
      do begin
        b = {1'b0, v[6:0]};
        v = v >> 7;
        if (v != 0) b[7] = 1'b1;
        frame_bytes.push_back(b);
      end while (v != 0);
    end
  endfunction

  task automatic send_frame(input int sel, input int payload_len, input frame_defect_t defect);
    logic [7:0]  code;
    logic [1:0]  eff;
    logic [31:0] ulen;
    logic [31:0] plen;
    logic [31:0] crc;
    int          cut;
    int          pos;
    bit          force_last;
    plen = payload_len;
    frame_bytes.delete();
    if (sel == 3) begin
      do code = 8'($urandom_range(0, 255));
      while (code == cur_cfg.raw_code || code == cur_cfg.comp_code ||
             code == cur_cfg.packed_code);
    end else if (sel == 0) code = cur_cfg.raw_code;
    else if (sel == 1) code = cur_cfg.comp_code;
    else code = cur_cfg.packed_code;
    if (code == cur_cfg.raw_code) eff = CODEC_RAW;
    else if (code == cur_cfg.comp_code) eff = CODEC_COMPRESSED;
    else eff = CODEC_PACKED;
    frame_bytes.push_back(code);

    if (sel == 3) begin
    end else if (defect == FRM_LONG_VARINT) begin
      repeat (5) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
    end else if (defect == FRM_OVER_CAP && cur_cfg.ulen_cap != 32'hFFFF_FFFF) begin
      ulen = cur_cfg.ulen_cap + 32'd1;
      if ($urandom_range(0, 1)) ulen = ulen + ($urandom % (~cur_cfg.ulen_cap));
      push_varint(ulen);
    end else begin
      if (eff == CODEC_COMPRESSED) begin
        if (cur_cfg.ulen_cap == 32'hFFFF_FFFF && $urandom_range(0, 1)) ulen = $urandom;
        else if ($urandom_range(0, 1) && cur_cfg.ulen_cap != 32'hFFFF_FFFF)
          ulen = $urandom % (cur_cfg.ulen_cap + 32'd1);
        else begin
          ulen = $urandom_range(0, 64);
          if (ulen > cur_cfg.ulen_cap) ulen = cur_cfg.ulen_cap;
        end
        push_varint(ulen);
        push_varint(plen);
      end else begin
        if (plen > cur_cfg.ulen_cap) plen = cur_cfg.ulen_cap;
        push_varint(plen);
      end
      repeat (plen) frame_bytes.push_back(8'($urandom_range(0, 255)));
      crc = CRC_INIT;
      foreach (frame_bytes[i]) crc = frame_tracker_t::crc_step(crc, frame_bytes[i]);
      crc = ~crc;
      for (int i = 0; i < 4; i++) frame_bytes.push_back(crc[8*i +: 8]);
      if (defect == FRM_BAD_CRC) begin
        pos = frame_bytes.size() - 1 - $urandom_range(0, 3);
        frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      if (defect == FRM_CORRUPT) begin
        pos = $urandom_range(0, frame_bytes.size() - 1);
        frame_bytes[pos] = frame_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
    end

    cut = frame_bytes.size() - 1;
    if (defect == FRM_TRUNCATED && cut > 0) cut = $urandom_range(0, cut - 1);
    force_last = (defect == FRM_TRUNCATED || defect == FRM_CORRUPT ||
                  $urandom_range(0, 9) == 0);
    for (int i = 0; i <= cut; i++) send_byte(frame_bytes[i], (i == cut) && force_last);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)),
                (i == n - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0));
  endtask

  initial begin
    int            pick;
    int            sel;
    int            plen;
    int            phase_end;
    frame_defect_t defect;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'd0;
    in_ch.source_end <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_CODEC_RAW;
    cfg_ch.data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short frame, then an over-cap length with a padded five-byte varint
    send_frame(0, 1, FRM_CLEAN);
    send_byte(cur_cfg.comp_code, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    // unknown codec, varint with continuation on the fifth byte, truncation
    send_byte(8'h7E, 1'b0);
    send_byte(cur_cfg.packed_code, 1'b0);
    repeat (4) send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(cur_cfg.raw_code, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hAA, 1'b1);
    // empty compressed payload
    send_frame(1, 0, FRM_CLEAN);
    wait_results_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_config(cfg_plan[ph]);
      sender_idle_pct    = sender_idle_by_mode[ph % 4];
      receiver_stall_pct = receiver_stall_by_mode[ph % 4];
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_noise();
        end else if (pick < 8) begin
          wait_results_drained();
        end else begin
          sel  = ($urandom_range(0, 99) < 8) ? 3 : $urandom_range(0, 2);
          plen = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
          pick = $urandom_range(0, 99);
          if (pick < 70) defect = FRM_CLEAN;
          else if (pick < 76) defect = FRM_BAD_CRC;
          else if (pick < 82) defect = FRM_TRUNCATED;
          else if (pick < 87) defect = FRM_CORRUPT;
          else if (pick < 92) defect = FRM_LONG_VARINT;
          else defect = FRM_OVER_CAP;
          send_frame(sel, plen, defect);
        end
      end
      // resync the parser before the next register set
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_results_drained();
    end

    wait_results_drained();
    if (frame_chk.finish_check() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
src/cfp_pkg.sv
src/cfp_if.sv
src/crc32c_checked_frame_parser.sv
src/cfp_checker.sv
tb/crc32c_checked_frame_parser_tb.sv
